[rtl/assert_macros.svh]
// Assertion macros used by the RTL of the buzzer sequencer.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside of reset
`define ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Check that a condition in one cycle leads to a consequence in the next
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/bzsos_pkg.sv]
// Package for the buzzer beep and SOS sequencer: item types, codes, constants
// and the Morse step table. Depends on nothing.
package bzsos_pkg;

    localparam int unsigned MS_W      = 16;
    localparam int unsigned STEP_W    = 5;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [STEP_W-1:0] NO_STEP   = 5'd31;
    localparam logic [STEP_W-1:0] LAST_STEP = 5'd16;

    // Register reset values
    localparam logic [MS_W-1:0] DOT_RESET    = 16'd100;
    localparam logic [MS_W-1:0] DASH_RESET   = 16'd300;
    localparam logic [MS_W-1:0] SGAP_RESET   = 16'd100;
    localparam logic [MS_W-1:0] LGAP_RESET   = 16'd300;
    localparam logic [MS_W-1:0] MAXBP_RESET  = 16'd2000;

    typedef enum logic [1:0] {
        ACT_TICK = 2'd0,
        ACT_BEEP = 2'd1,
        ACT_SOS  = 2'd2
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DOT_LENGTH  = 3'd0,
        CFG_DASH_LENGTH = 3'd1,
        CFG_SYMBOL_GAP  = 3'd2,
        CFG_LETTER_GAP  = 3'd3,
        CFG_MAX_BEEP    = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_DOT,
        KIND_DASH,
        KIND_SYMBOL_GAP,
        KIND_LETTER_GAP
    } step_kind_t;

    typedef struct packed {
        action_t         action;
        logic [MS_W-1:0] beep_ms;
    } in_item_t;

    typedef struct packed {
        logic              buzzer_on;
        logic              busy_res;
        logic [STEP_W-1:0] step_index;
        logic [MS_W-1:0]   beep_total;
        logic [MS_W-1:0]   sequence_total;
    } out_item_t;

    // Morse pattern S O S: even steps sound, odd steps are silent
    function automatic step_kind_t sos_kind(input logic [STEP_W-1:0] idx);
        step_kind_t kind;
        case (idx) inside
            5'd5, 5'd11:                               kind = KIND_LETTER_GAP;
            5'd6, 5'd8, 5'd10:                         kind = KIND_DASH;
            5'd1, 5'd3, 5'd7, 5'd9, 5'd13, 5'd15:      kind = KIND_SYMBOL_GAP;
            default:                                   kind = KIND_DOT;
        endcase
        return kind;
    endfunction

endpackage

[rtl/buzzer_beep_and_sos_sequencer.sv]
// Buzzer beep and Morse SOS sequencer, top level.
// Depends on bzsos_pkg and assert_macros.svh.
//
// One input item (tick, beep request or SOS start) is taken per clock cycle
// and its result item appears in the output register on the next cycle. The
// whole update of timer, step and counters is one pass of logic from the
// state registers to the result register, so the rate is one item per cycle;
// input ready follows the output register: an item is taken whenever the
// result register is empty or its item is taken in the same cycle. The
// configuration port is always ready and its writes apply from the next item.
module buzzer_beep_and_sos_sequencer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  bzsos_pkg::in_item_t               in_item,
    output logic                              out_valid,
    input  logic                              out_ready,
    output bzsos_pkg::out_item_t              out_item,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bzsos_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bzsos_pkg::MS_W-1:0]        cfg_data
);
    import bzsos_pkg::*;

    // Configuration registers
    logic [MS_W-1:0] dot_len_reg;
    logic [MS_W-1:0] dash_len_reg;
    logic [MS_W-1:0] sym_gap_reg;
    logic [MS_W-1:0] let_gap_reg;
    logic [MS_W-1:0] max_beep_reg;

    // Playback state
    logic [MS_W-1:0]   period_reg,   period_next;
    logic [MS_W-1:0]   elapsed_reg,  elapsed_next;
    logic              in_seq_reg,   in_seq_next;
    logic [STEP_W-1:0] step_reg,     step_next;
    logic              drive_reg,    drive_next;
    logic [MS_W-1:0]   beep_cnt_reg, beep_cnt_next;
    logic [MS_W-1:0]   seq_cnt_reg,  seq_cnt_next;

    // Result register
    logic      out_valid_reg;
    out_item_t out_item_reg;

    logic              accept;
    logic [MS_W-1:0]   tick_elapsed;
    logic [MS_W-1:0]   beep_len;
    logic [STEP_W-1:0] start_idx;
    logic [MS_W-1:0]   start_len;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_len_reg  <= DOT_RESET;
            dash_len_reg <= DASH_RESET;
            sym_gap_reg  <= SGAP_RESET;
            let_gap_reg  <= LGAP_RESET;
            max_beep_reg <= MAXBP_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_DOT_LENGTH:  dot_len_reg  <= cfg_data;
                CFG_DASH_LENGTH: dash_len_reg <= cfg_data;
                CFG_SYMBOL_GAP:  sym_gap_reg  <= cfg_data;
                CFG_LETTER_GAP:  let_gap_reg  <= cfg_data;
                CFG_MAX_BEEP:    max_beep_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Pick the step to start and look up its length
    always_comb
    begin
        start_idx = (in_item.action == ACT_SOS) ? '0 : STEP_W'(step_reg + 1'b1);
        unique case (sos_kind(start_idx))
            KIND_DOT:        start_len = dot_len_reg;
            KIND_DASH:       start_len = dash_len_reg;
            KIND_SYMBOL_GAP: start_len = sym_gap_reg;
            default:         start_len = let_gap_reg;
        endcase
    end

    assign tick_elapsed = MS_W'(elapsed_reg + 1'b1);
    assign beep_len     = (in_item.beep_ms > max_beep_reg) ? max_beep_reg : in_item.beep_ms;

    // Compute the state after one item
    always_comb
    begin
        logic start_step;
        logic go_idle;
        start_step    = 1'b0;
        go_idle       = 1'b0;
        period_next   = period_reg;
        elapsed_next  = elapsed_reg;
        in_seq_next   = in_seq_reg;
        step_next     = step_reg;
        drive_next    = drive_reg;
        beep_cnt_next = beep_cnt_reg;
        seq_cnt_next  = seq_cnt_reg;

        case (in_item.action)
            ACT_TICK:
            begin
                if (period_reg != '0)
                begin
                    elapsed_next = tick_elapsed;
                    if (tick_elapsed >= period_reg)
                    begin
                        if (in_seq_reg && (step_reg < LAST_STEP))
                            start_step = 1'b1;
                        else
                            go_idle = 1'b1;
                    end
                end
            end
            ACT_BEEP:
            begin
                if (beep_len != '0)
                begin
                    beep_cnt_next = MS_W'(beep_cnt_reg + 1'b1);
                    period_next   = beep_len;
                    elapsed_next  = '0;
                    in_seq_next   = 1'b0;
                    step_next     = NO_STEP;
                    drive_next    = 1'b1;
                end
            end
            ACT_SOS:
            begin
                seq_cnt_next = MS_W'(seq_cnt_reg + 1'b1);
                start_step   = 1'b1;
            end
            default: ;
        endcase

        // A step of zero length ends playback
        if (start_step)
        begin
            if (start_len == '0)
                go_idle = 1'b1;
            else
            begin
                in_seq_next  = 1'b1;
                step_next    = start_idx;
                period_next  = start_len;
                elapsed_next = '0;
                drive_next   = !start_idx[0];
            end
        end

        if (go_idle)
        begin
            period_next  = '0;
            elapsed_next = '0;
            in_seq_next  = 1'b0;
            step_next    = NO_STEP;
            drive_next   = 1'b0;
        end
    end

    // Advance state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg   <= '0;
            elapsed_reg  <= '0;
            in_seq_reg   <= 1'b0;
            step_reg     <= NO_STEP;
            drive_reg    <= 1'b0;
            beep_cnt_reg <= '0;
            seq_cnt_reg  <= '0;
        end
        else if (accept)
        begin
            period_reg   <= period_next;
            elapsed_reg  <= elapsed_next;
            in_seq_reg   <= in_seq_next;
            step_reg     <= step_next;
            drive_reg    <= drive_next;
            beep_cnt_reg <= beep_cnt_next;
            seq_cnt_reg  <= seq_cnt_next;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_ready)
            out_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_item_reg.buzzer_on      <= drive_next;
            out_item_reg.busy_res       <= (period_next != '0);
            out_item_reg.step_index     <= step_next;
            out_item_reg.beep_total     <= beep_cnt_next;
            out_item_reg.sequence_total <= seq_cnt_next;
        end
    end

`include "assert_macros.svh"

    // Idle means silent with no step
    `ASSERT_ALWAYS(a_idle_silent, (period_reg != '0) || (!drive_reg && step_reg == NO_STEP))
    // A running sequence sits on a real step
    `ASSERT_ALWAYS(a_seq_step, !in_seq_reg || (step_reg <= LAST_STEP))
    // A running period has not yet reached its length
    `ASSERT_ALWAYS(a_elapsed_short, (period_reg == '0) || (elapsed_reg < period_reg))
    // Each accepted SOS start bumps the sequence count by one
    `ASSERT_NEXT(a_sos_count, accept && in_item.action == ACT_SOS, seq_cnt_reg == MS_W'($past(seq_cnt_reg) + 1'b1))
    // A held result does not change while it waits
    `ASSERT_NEXT(a_out_hold, out_valid_reg && !out_ready, out_valid_reg && $stable(out_item_reg))

endmodule
